@@ src/udpdq_pkg.sv @@
package udpdq_pkg;

  localparam logic [1:0] ACT_BIND    = 2'd0;
  localparam logic [1:0] ACT_DELIVER = 2'd1;
  localparam logic [1:0] ACT_RECV    = 2'd2;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_BOUND  = 3'd1;
  localparam logic [2:0] STS_FULL   = 3'd2;
  localparam logic [2:0] STS_DROP   = 3'd3;
  localparam logic [2:0] STS_NOBIND = 3'd4;
  localparam logic [2:0] STS_EMPTY  = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] port;
    logic        is_udp;
    logic [15:0] buffer_handle;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] handle_out;
    logic [3:0]  socket_index;
  } rsp_item_t;

  // walk results of the slot table; done pulses when match/free are final
  typedef struct packed {
    logic done;
    logic match;
    logic free;
  } scan_flags_t;

endpackage

@@ src/udpdq_slot_table.sv @@
module udpdq_slot_table #(
  parameter int NUM_SOCKETS = 16,
  parameter int SW = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [15:0]            key,
  input  logic                   bind_we,
  input  logic [SW-1:0]          bind_idx,
  input  logic [15:0]            bind_port,
  output udpdq_pkg::scan_flags_t flags,
  output logic [SW-1:0]          match_idx,
  output logic [SW-1:0]          free_idx
);

  localparam int CW = $clog2(NUM_SOCKETS + 1);

  logic [NUM_SOCKETS-1:0] slot_valid;
  logic [15:0]            port_mem [NUM_SOCKETS];

  logic          busy;
  logic [CW-1:0] cnt;
  logic          rd_live;
  logic [SW-1:0] rd_idx;
  logic [15:0]   rd_port;
  logic          done;
  logic          match;
  logic          free;

  // read stage: one slot port per cycle
  always_ff @(posedge clk) begin
    rd_port <= port_mem[cnt[SW-1:0]];
    rd_idx  <= cnt[SW-1:0];
    if (bind_we) begin
      port_mem[bind_idx] <= bind_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      busy       <= 1'b0;
      cnt        <= '0;
      rd_live    <= 1'b0;
      done       <= 1'b0;
      match      <= 1'b0;
      free       <= 1'b0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        match <= 1'b0;
        free  <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_SOCKETS - 1)) begin
          busy <= 1'b0;
        end
      end
      rd_live <= busy && !start;
      done    <= rd_live && (rd_idx == SW'(NUM_SOCKETS - 1));
      // compare stage; first hit in index order wins
      if (rd_live) begin
        if (!match && slot_valid[rd_idx] && (rd_port == key)) begin
          match     <= 1'b1;
          match_idx <= rd_idx;
        end
        if (!free && !slot_valid[rd_idx]) begin
          free     <= 1'b1;
          free_idx <= rd_idx;
        end
      end
      if (bind_we) begin
        slot_valid[bind_idx] <= 1'b1;
      end
    end
  end

  assign flags.done  = done;
  assign flags.match = match;
  assign flags.free  = free;

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rd_live) && ($past(rd_idx) == SW'(NUM_SOCKETS - 1)))
    else $error("scan done without a last-slot compare");

  a_bind_free_slot: assert property (@(posedge clk) disable iff (rst)
    bind_we |-> !slot_valid[bind_idx])
    else $error("bind into a slot already in use");

  a_no_live_idle: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> $past(busy))
    else $error("compare stage live without a read");

endmodule

@@ src/udp_port_demux_queues_core.sv @@
// UDP port demultiplexer with one ring queue of buffer handles per socket.
// One request is handled at a time; req_stall stays high from the transfer
// of a request until its response has been loaded into the output register.
// Bind, deliver and receive walk the slot table through a single port
// comparator, one slot per cycle. A bind, or a deliver or receive whose port
// is not bound, goes from the walk straight to the response. A deliver that
// finds its socket, or a receive on an empty queue, adds a head/tail read.
// A receive that pops a handle also adds a queue memory read. A non-UDP
// deliver or an unknown action skips the walk. The next request can transfer
// in the same cycle that rsp_valid rises. A queue holds at most
// QUEUE_DEPTH - 1 handles; receive on an empty queue answers "queue empty".
// No clearing pass is needed after reset.
module udp_port_demux_queues_core #(
  parameter int NUM_SOCKETS = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  udpdq_pkg::req_item_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output udpdq_pkg::rsp_item_t rsp
);

  localparam int SW = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
  localparam int QB = $clog2(QUEUE_DEPTH);
  localparam int HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_HT   = 3'd2;
  localparam logic [2:0] ST_QRD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state, state_next;
  logic [1:0]    act_q;
  logic [15:0]   port_q;
  logic [HB-1:0] handle_q;
  logic [SW-1:0] sidx, sidx_next;
  logic [2:0]    res_status, res_status_next;
  logic [HB-1:0] res_handle, res_handle_next;
  logic [SW-1:0] res_idx, res_idx_next;

  logic [QB-1:0] head_mem [NUM_SOCKETS];
  logic [QB-1:0] tail_mem [NUM_SOCKETS];
  logic [HB-1:0] qmem [NUM_SOCKETS][QUEUE_DEPTH];
  logic [QB-1:0] h_rd, t_rd;
  logic [HB-1:0] q_rd;

  logic          scan_start;
  logic          bind_we;
  logic          head_we, tail_we, q_we;
  logic [SW-1:0] head_wa, tail_wa;
  logic [QB-1:0] head_wd, tail_wd;

  udpdq_pkg::scan_flags_t flags;
  logic [SW-1:0]          match_idx;
  logic [SW-1:0]          free_idx;
  logic [SW+3:0]          idx_ext;

  function automatic logic [QB-1:0] wrap_inc(input logic [QB-1:0] v);
    return (v == QB'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  udpdq_slot_table #(
    .NUM_SOCKETS(NUM_SOCKETS),
    .SW(SW)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .key      (port_q),
    .bind_we  (bind_we),
    .bind_idx (free_idx),
    .bind_port(port_q),
    .flags    (flags),
    .match_idx(match_idx),
    .free_idx (free_idx)
  );

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    sidx_next       = sidx;
    res_status_next = res_status;
    res_handle_next = res_handle;
    res_idx_next    = res_idx;
    scan_start      = 1'b0;
    bind_we         = 1'b0;
    head_we         = 1'b0;
    tail_we         = 1'b0;
    q_we            = 1'b0;
    head_wa         = sidx;
    tail_wa         = sidx;
    head_wd         = wrap_inc(h_rd);
    tail_wd         = wrap_inc(t_rd);
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          res_handle_next = '0;
          res_idx_next    = '0;
          unique case (req.action) inside
            udpdq_pkg::ACT_BIND, udpdq_pkg::ACT_RECV: begin
              scan_start = 1'b1;
              state_next = ST_SCAN;
            end
            udpdq_pkg::ACT_DELIVER: begin
              if (req.is_udp) begin
                scan_start = 1'b1;
                state_next = ST_SCAN;
              end else begin
                res_status_next = udpdq_pkg::STS_DROP;
                res_handle_next = req.buffer_handle[HB-1:0];
                state_next      = ST_DONE;
              end
            end
            default: begin
              res_status_next = udpdq_pkg::STS_NOBIND;
              state_next      = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (flags.done) begin
          sidx_next = match_idx;
          unique case (act_q) inside
            udpdq_pkg::ACT_BIND: begin
              state_next = ST_DONE;
              if (flags.match) begin
                res_status_next = udpdq_pkg::STS_BOUND;
                res_idx_next    = match_idx;
              end else if (flags.free) begin
                bind_we         = 1'b1;
                head_we         = 1'b1;
                tail_we         = 1'b1;
                head_wa         = free_idx;
                tail_wa         = free_idx;
                head_wd         = '0;
                tail_wd         = '0;
                res_status_next = udpdq_pkg::STS_OK;
                res_idx_next    = free_idx;
              end else begin
                res_status_next = udpdq_pkg::STS_FULL;
              end
            end
            udpdq_pkg::ACT_DELIVER: begin
              if (flags.match) begin
                state_next = ST_HT;
              end else begin
                res_status_next = udpdq_pkg::STS_DROP;
                res_handle_next = handle_q;
                state_next      = ST_DONE;
              end
            end
            default: begin
              if (flags.match) begin
                state_next = ST_HT;
              end else begin
                res_status_next = udpdq_pkg::STS_NOBIND;
                state_next      = ST_DONE;
              end
            end
          endcase
        end
      end
      ST_HT: begin
        res_idx_next = sidx;
        state_next   = ST_DONE;
        if (act_q == udpdq_pkg::ACT_DELIVER) begin
          if (wrap_inc(h_rd) == t_rd) begin
            res_status_next = udpdq_pkg::STS_DROP;
            res_handle_next = handle_q;
          end else begin
            q_we            = 1'b1;
            head_we         = 1'b1;
            res_status_next = udpdq_pkg::STS_OK;
          end
        end else if (h_rd == t_rd) begin
          res_status_next = udpdq_pkg::STS_EMPTY;
        end else begin
          tail_we    = 1'b1;
          state_next = ST_QRD;
        end
      end
      ST_QRD: begin
        res_status_next = udpdq_pkg::STS_OK;
        res_handle_next = q_rd;
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && state_next == ST_IDLE) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign idx_ext = {4'b0, res_idx};

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      act_q    <= req.action;
      port_q   <= req.port;
      handle_q <= req.buffer_handle[HB-1:0];
    end
    sidx       <= sidx_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
    res_idx    <= res_idx_next;
    if (state == ST_DONE && state_next == ST_IDLE) begin
      rsp.status       <= res_status;
      rsp.handle_out   <= 16'(res_handle);
      rsp.socket_index <= idx_ext[3:0];
    end
  end

  // head/tail and queue memories, registered reads
  always_ff @(posedge clk) begin
    h_rd <= head_mem[match_idx];
    t_rd <= tail_mem[match_idx];
    q_rd <= qmem[sidx][t_rd];
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    if (q_we) begin
      qmem[sidx][h_rd] <= handle_q;
    end
  end

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    flags.done |-> (state == ST_SCAN))
    else $error("slot walk finished outside the scan state");

  a_qrd_after_ht: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRD) |-> ($past(state) == ST_HT))
    else $error("queue read without a head/tail lookup");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_we |-> (wrap_inc(h_rd) != t_rd) && (act_q == udpdq_pkg::ACT_DELIVER))
    else $error("push into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (tail_we && state == ST_HT) |-> (h_rd != t_rd))
    else $error("pop from an empty queue");

endmodule

@@ verif/udp_port_demux_queues_checker.sv @@
`timescale 1ns / 100ps

module udp_port_demux_queues_checker #(
  parameter int NUM_SOCKETS = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  udpdq_pkg::req_item_t req,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  udpdq_pkg::rsp_item_t rsp,
  output int                   err_count,
  output int                   pending,
  output int                   checked
);

  // shadow copy of the socket table and its ring queues
  bit          sock_bound [NUM_SOCKETS];
  logic [15:0] sock_port  [NUM_SOCKETS];
  logic [15:0] ring_buf   [NUM_SOCKETS][QUEUE_DEPTH];
  int          ring_head  [NUM_SOCKETS];
  int          ring_tail  [NUM_SOCKETS];

  udpdq_pkg::rsp_item_t expected_rsps [$];
  int mism_count;
  int rsp_count;

  // lowest bound slot holding this port, -1 if none
  function automatic int find_socket(logic [15:0] p);
    for (int i = 0; i < NUM_SOCKETS; i++) begin
      if (sock_bound[i] && sock_port[i] == p) return i;
    end
    return -1;
  endfunction

  function automatic udpdq_pkg::rsp_item_t demux_outcome(udpdq_pkg::req_item_t r);
    udpdq_pkg::rsp_item_t o;
    int        s;
    int        nxt;
    o = '0;
    s = find_socket(r.port);
    case (r.action)
      udpdq_pkg::ACT_BIND: begin
        if (s >= 0) begin
          o.status       = udpdq_pkg::STS_BOUND;
          o.socket_index = 4'(s);
        end else begin
          o.status = udpdq_pkg::STS_FULL;
          for (int i = 0; i < NUM_SOCKETS; i++) begin
            if (!sock_bound[i]) begin
              sock_bound[i]  = 1'b1;
              sock_port[i]   = r.port;
              ring_head[i]   = 0;
              ring_tail[i]   = 0;
              o.status       = udpdq_pkg::STS_OK;
              o.socket_index = 4'(i);
              break;
            end
          end
        end
      end
      udpdq_pkg::ACT_DELIVER: begin
        if (!r.is_udp || s < 0) begin
          o.status     = udpdq_pkg::STS_DROP;
          o.handle_out = r.buffer_handle;
        end else begin
          nxt = (ring_head[s] + 1) % QUEUE_DEPTH;
          o.socket_index = 4'(s);
          if (nxt == ring_tail[s]) begin
            // ring full: one slot is always left empty
            o.status     = udpdq_pkg::STS_DROP;
            o.handle_out = r.buffer_handle;
          end else begin
            ring_buf[s][ring_head[s]] = r.buffer_handle;
            ring_head[s] = nxt;
            o.status     = udpdq_pkg::STS_OK;
          end
        end
      end
      udpdq_pkg::ACT_RECV: begin
        if (s < 0) begin
          o.status = udpdq_pkg::STS_NOBIND;
        end else begin
          o.socket_index = 4'(s);
          if (ring_head[s] == ring_tail[s]) begin
            o.status = udpdq_pkg::STS_EMPTY;
          end else begin
            o.status     = udpdq_pkg::STS_OK;
            o.handle_out = ring_buf[s][ring_tail[s]];
            ring_tail[s] = (ring_tail[s] + 1) % QUEUE_DEPTH;
          end
        end
      end
      default: o.status = udpdq_pkg::STS_NOBIND;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    udpdq_pkg::rsp_item_t want;
    if (rst) begin
      expected_rsps.delete();
      for (int i = 0; i < NUM_SOCKETS; i++) begin
        sock_bound[i] = 1'b0;
        ring_head[i]  = 0;
        ring_tail[i]  = 0;
      end
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          mism_count++;
          if (mism_count <= 10) begin
            $display("%0t: response with none outstanding: status %0d handle %h slot %0d",
                     $realtime, rsp.status, rsp.handle_out, rsp.socket_index);
          end
        end else begin
          want = expected_rsps.pop_front();
          rsp_count++;
          if (rsp.status !== want.status || rsp.handle_out !== want.handle_out ||
              rsp.socket_index !== want.socket_index) begin
            mism_count++;
            if (mism_count <= 10) begin
              $display("%0t: mismatch: expected status %0d handle %h slot %0d, got %0d %h %0d",
                       $realtime, want.status, want.handle_out, want.socket_index,
                       rsp.status, rsp.handle_out, rsp.socket_index);
            end
          end
        end
      end
      if (req_valid && !req_stall) expected_rsps.push_back(demux_outcome(req));
    end
    err_count <= mism_count;
    pending   <= expected_rsps.size();
    checked   <= rsp_count;
  end

endmodule

@@ verif/udp_port_demux_queues_core_test.sv @@
`timescale 1ns / 100ps

module udp_port_demux_queues_core_test;

  localparam logic [1:0] ACT_UNKNOWN     = 2'd3;
  localparam int         POOL_SIZE       = 24;
  localparam int         ITEMS_PER_PHASE = 235;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 rsp_stall = 1'b0;
  udpdq_pkg::req_item_t req       = '0;
  logic                 req_stall;
  logic                 rsp_valid;
  udpdq_pkg::rsp_item_t rsp;

  int err_count;
  int pending;
  int checked;
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;

  logic [15:0] port_pool [POOL_SIZE];

  udp_port_demux_queues_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  udp_port_demux_queues_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .err_count (err_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // worst case is ~1000 items; this timeout is far beyond what they need
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic udpdq_pkg::req_item_t mk_req(logic [1:0] a, logic [15:0] p, logic u,
                                                  logic [15:0] h);
    udpdq_pkg::req_item_t x;
    x.action        = a;
    x.port          = p;
    x.is_udp        = u;
    x.buffer_handle = h;
    return x;
  endfunction

  // mostly ports from a small pool so lookups hit; some fully random ones miss
  function automatic logic [15:0] pick_port();
    if ($urandom_range(0, 99) < 85) return port_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(udpdq_pkg::req_item_t x);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= x;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  // hold off the sender until every outstanding response is back
  task automatic drain_results();
    int guard;
    guard = 0;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic send_random();
    int         r;
    logic [1:0] a;
    r = $urandom_range(0, 99);
    if (r < 15) a = udpdq_pkg::ACT_BIND;
    else if (r < 55) a = udpdq_pkg::ACT_DELIVER;
    else if (r < 92) a = udpdq_pkg::ACT_RECV;
    else a = ACT_UNKNOWN;
    send_item(mk_req(a, pick_port(), $urandom_range(0, 99) < 85, 16'($urandom)));
  endtask

  initial begin : stimulus
    int          kind;
    int          n;
    int          target;
    logic [15:0] p;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) port_pool[i] = 16'($urandom_range(0, 65535));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: port extremes, duplicate bind, misses, drops, FIFO order
    send_item(mk_req(udpdq_pkg::ACT_BIND,    16'h0000, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_BIND,    16'h0000, 1'b1, 16'hFFFF));
    send_item(mk_req(udpdq_pkg::ACT_BIND,    16'hFFFF, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_RECV,    16'h0000, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_RECV,    16'h1234, 1'b1, 16'hFFFF));
    send_item(mk_req(udpdq_pkg::ACT_DELIVER, 16'h0000, 1'b0, 16'hFFFF));
    send_item(mk_req(udpdq_pkg::ACT_DELIVER, 16'h8001, 1'b1, 16'h5A5A));
    send_item(mk_req(udpdq_pkg::ACT_DELIVER, 16'h0000, 1'b1, 16'hFFFF));
    send_item(mk_req(udpdq_pkg::ACT_DELIVER, 16'h0000, 1'b1, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_DELIVER, 16'hFFFF, 1'b1, 16'hA5C3));
    send_item(mk_req(udpdq_pkg::ACT_RECV,    16'h0000, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_RECV,    16'h0000, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_RECV,    16'h0000, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_RECV,    16'hFFFF, 1'b1, 16'hFFFF));
    send_item(mk_req(ACT_UNKNOWN,            16'hFFFF, 1'b1, 16'hFFFF));
    send_item(mk_req(ACT_UNKNOWN,            16'h0000, 1'b0, 16'h0000));
    send_item(mk_req(udpdq_pkg::ACT_BIND,    16'h00FF, 1'b1, 16'hFFFF));
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        kind = $urandom_range(0, 99);
        p    = pick_port();
        if (kind < 20) begin
          // burst of deliveries long enough to fill a ring
          n = $urandom_range(1, 18);
          repeat (n) send_item(mk_req(udpdq_pkg::ACT_DELIVER, p,
                                      $urandom_range(0, 19) != 0, 16'($urandom)));
        end else if (kind < 38) begin
          n = $urandom_range(1, 18);
          repeat (n) send_item(mk_req(udpdq_pkg::ACT_RECV, p, 1'($urandom_range(0, 1)),
                                      16'($urandom)));
        end else begin
          send_random();
        end
      end
      drain_results();
    end

    repeat (30) @(posedge clk);
    $display("%0d requests over four flow-control mixes; %0d responses compared, %0d bad",
             sent, checked, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
